// ===== hdl/eas_pkg.sv =====
// Shared types, character codes and the character classifier for the address scanner.
// No dependencies; imported by every module of the scanner.
`timescale 1ns / 1ps

package eas_pkg;

    localparam int MAX_LINE_DEFAULT = 4096;

    localparam logic [7:0] CH_AT      = 8'd64;
    localparam logic [7:0] CH_DOT     = 8'd46;
    localparam logic [7:0] CH_USCORE  = 8'd95;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DIGIT_0 = 8'd48;
    localparam logic [7:0] CH_DIGIT_9 = 8'd57;

    typedef struct packed {
        logic eol;
        logic is_at;
        logic is_dot;
        logic is_addr;
    } char_class_t;

    function automatic char_class_t classify(input logic [7:0] ch, input logic eol);
        char_class_t cls;
        cls.eol     = eol;
        cls.is_at   = (ch == CH_AT);
        cls.is_dot  = (ch == CH_DOT);
        cls.is_addr = ch inside {[CH_UPPER_A:CH_UPPER_Z], [CH_LOWER_A:CH_LOWER_Z],
                                 [CH_DIGIT_0:CH_DIGIT_9], CH_USCORE, CH_DOT,
                                 CH_MINUS, CH_PLUS};
        return cls;
    endfunction

endpackage

// ===== hdl/eas_in_stage.sv =====
// Input register of the address scanner: classifies each request and holds it.
// Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_in_stage
    import eas_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        is_line_end,
    input  logic        advance,
    output logic        item_valid,
    output char_class_t item_class
);

    logic        full_reg;
    logic        full_next;
    char_class_t class_reg;
    logic        load;

    assign in_ready   = !full_reg || advance;
    assign load       = in_valid && in_ready;
    assign item_valid = full_reg;
    assign item_class = class_reg;

    always_comb
    begin
        full_next = full_reg;
        if (load)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            class_reg <= classify(ch, is_line_end);
        end
    end

endmodule

// ===== hdl/eas_scan.sv =====
// Scanner state and next-state logic: tracks left run, '@', dot and line position.
// Depends on eas_pkg.
`timescale 1ns / 1ps

module eas_scan
    import eas_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEFAULT,
    parameter int POS_W    = $clog2(MAX_LINE),
    parameter int LEN_W    = POS_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  char_class_t      item_class,
    output logic             hit,
    output logic [POS_W-1:0] hit_start,
    output logic [LEN_W-1:0] hit_length
);

    localparam logic [LEN_W-1:0] POS_LIMIT = LEN_W'(MAX_LINE);
    localparam logic [LEN_W-1:0] DOT_GAP   = LEN_W'(2);

    logic             after_at_reg,   after_at_next;
    logic [LEN_W-1:0] line_pos_reg,   line_pos_next;
    logic             run_active_reg, run_active_next;
    logic [POS_W-1:0] run_begin_reg,  run_begin_next;
    logic [POS_W-1:0] at_index_reg,   at_index_next;
    logic             dot_ok_reg,     dot_ok_next;

    logic             saturated;
    logic [LEN_W-1:0] at_dist;

    assign saturated  = (line_pos_reg >= POS_LIMIT);
    assign at_dist    = line_pos_reg - {1'b0, at_index_reg};
    assign hit_start  = run_begin_reg;
    assign hit_length = line_pos_reg - {1'b0, run_begin_reg};

    always_comb
    begin
        after_at_next   = after_at_reg;
        line_pos_next   = line_pos_reg;
        run_active_next = run_active_reg;
        run_begin_next  = run_begin_reg;
        at_index_next   = at_index_reg;
        dot_ok_next     = dot_ok_reg;
        hit             = 1'b0;

        if (after_at_reg)
        begin
            if (!item_class.eol && item_class.is_addr)
            begin
                if (saturated)
                begin
                    run_active_next = 1'b0;
                end
                else if (item_class.is_dot && at_dist >= DOT_GAP)
                begin
                    dot_ok_next = 1'b1;
                end
            end
            else
            begin
                // terminator of the right part: report and consume it
                hit             = run_active_reg && dot_ok_reg;
                after_at_next   = 1'b0;
                run_active_next = 1'b0;
                dot_ok_next     = 1'b0;
            end
        end
        else if (!item_class.eol)
        begin
            if (item_class.is_at)
            begin
                if (saturated)
                begin
                    run_active_next = 1'b0;
                end
                after_at_next = 1'b1;
                at_index_next = saturated ? '0 : line_pos_reg[POS_W-1:0];
                dot_ok_next   = 1'b0;
            end
            else if (item_class.is_addr)
            begin
                if (saturated)
                begin
                    run_active_next = 1'b0;
                end
                else if (!run_active_reg)
                begin
                    run_active_next = 1'b1;
                    run_begin_next  = line_pos_reg[POS_W-1:0];
                end
            end
            else
            begin
                run_active_next = 1'b0;
            end
        end

        if (item_class.eol)
        begin
            after_at_next   = 1'b0;
            line_pos_next   = '0;
            run_active_next = 1'b0;
            run_begin_next  = '0;
            at_index_next   = '0;
            dot_ok_next     = 1'b0;
        end
        else if (!saturated)
        begin
            line_pos_next = line_pos_reg + LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            after_at_reg   <= 1'b0;
            line_pos_reg   <= '0;
            run_active_reg <= 1'b0;
            run_begin_reg  <= '0;
            at_index_reg   <= '0;
            dot_ok_reg     <= 1'b0;
        end
        else if (advance)
        begin
            after_at_reg   <= after_at_next;
            line_pos_reg   <= line_pos_next;
            run_active_reg <= run_active_next;
            run_begin_reg  <= run_begin_next;
            at_index_reg   <= at_index_next;
            dot_ok_reg     <= dot_ok_next;
        end
    end

endmodule

// ===== hdl/email_address_scanner_core.sv =====
// Address scanner: one byte per cycle in, start offset and length of each found address out.
// One request per clock sustained while no back-pressure holds it; a byte passes the input
// register, then the scan logic loads the result register from it.
// Back-pressure reaches the input only while the result register is full and not taken.
// Top level; depends on eas_pkg, eas_in_stage and eas_scan.
`timescale 1ns / 1ps

module email_address_scanner_core
    import eas_pkg::*;
#(
    parameter int MAX_LINE = MAX_LINE_DEFAULT,
    parameter int POS_W    = $clog2(MAX_LINE),
    parameter int LEN_W    = POS_W + 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       ch,
    input  logic             is_line_end,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [POS_W-1:0] email_start,
    output logic [LEN_W-1:0] email_length
);

    logic             item_valid;
    char_class_t      item_class;
    logic             advance;
    logic             hit;
    logic [POS_W-1:0] hit_start;
    logic [LEN_W-1:0] hit_length;

    logic             out_valid_reg, out_valid_next;
    logic [POS_W-1:0] start_reg;
    logic [LEN_W-1:0] length_reg;

    // advance the held byte whenever the result slot is free or being drained
    assign advance = item_valid && (!out_valid_reg || out_ready);

    eas_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .ch         (ch),
        .is_line_end(is_line_end),
        .advance    (advance),
        .item_valid (item_valid),
        .item_class (item_class)
    );

    eas_scan #(
        .MAX_LINE(MAX_LINE),
        .POS_W   (POS_W),
        .LEN_W   (LEN_W)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .item_class(item_class),
        .hit       (hit),
        .hit_start (hit_start),
        .hit_length(hit_length)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = hit;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && hit)
        begin
            start_reg  <= hit_start;
            length_reg <= hit_length;
        end
    end

    assign out_valid    = out_valid_reg;
    assign email_start  = start_reg;
    assign email_length = length_reg;

    // a reported address has a left character, '@', and at least two right characters
    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (email_length >= LEN_W'(4)))
        else $error("address shorter than four characters");

    a_within_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (({1'b0, email_start} + email_length) <= (LEN_W + 1)'(MAX_LINE)))
        else $error("address reaches past the line limit");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input held off while the result slot is free");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !item_valid) |=> !out_valid)
        else $error("result repeated after it was taken");

endmodule
